// ----- design/pulse_channel_frame_sequencer_macros.svh -----
// Assertion macros for the pulse channel frame sequencer checker.
// No dependencies; included by the checker file only.
`ifndef PULSE_CHANNEL_FRAME_SEQUENCER_MACROS_SVH
`define PULSE_CHANNEL_FRAME_SEQUENCER_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PCFS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: implication failed");

// Next-cycle implication, ignored while reset is asserted.
`define PCFS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

// Next-cycle implication that also holds through reset.
`define PCFS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- design/pcfs_pkg.sv -----
// Shared types, constants and the length table of the pulse channel frame sequencer.
// No dependencies; imported by every module of the block.
package pcfs_pkg;

    localparam int NUM_PULSE = 2;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_ENVELOPE = 3'd1;
    localparam logic [2:0] REG_SWEEP    = 3'd2;
    localparam logic [2:0] REG_TIMER_LO = 3'd3;
    localparam logic [2:0] REG_TIMER_HI = 3'd4;
    localparam logic [2:0] REG_LENGTH   = 3'd5;
    localparam logic [2:0] REG_FRAME    = 3'd6;

    // Frame sequencer step counts
    localparam logic [15:0] FRM_QUARTER_1 = 16'd7457;
    localparam logic [15:0] FRM_HALF_1    = 16'd14913;
    localparam logic [15:0] FRM_QUARTER_3 = 16'd22371;
    localparam logic [15:0] FRM_HALF_4    = 16'd29829;
    localparam logic [15:0] FRM_HALF_5    = 16'd37281;
    localparam logic [15:0] FRM_WRAP_4    = 16'd29830;
    localparam logic [15:0] FRM_WRAP_5    = 16'd37282;

    localparam logic [10:0] PERIOD_MAX   = 11'h7ff;
    localparam logic [10:0] PERIOD_MIN   = 11'd8;
    localparam logic [3:0]  ENV_MAX      = 4'd15;
    localparam logic [7:0]  LENGTH_RESET = 8'd7;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 32;

    typedef struct packed {
        logic       wr_en;
        logic [2:0] sel;
        logic [7:0] data;
    } pcfs_wr_t;

    typedef struct packed {
        logic quarter;
        logic half;
    } pcfs_frame_t;

    typedef struct packed {
        logic [3:0]  vol;
        logic [10:0] period;
        logic        audible;
    } pcfs_chan_out_t;

    function automatic logic [7:0] len_lookup(input logic [4:0] idx);
        logic [7:0] v;
        case (idx)
            5'd0:  v = 8'd10;
            5'd1:  v = 8'd254;
            5'd2:  v = 8'd20;
            5'd3:  v = 8'd2;
            5'd4:  v = 8'd40;
            5'd5:  v = 8'd4;
            5'd6:  v = 8'd80;
            5'd7:  v = 8'd6;
            5'd8:  v = 8'd160;
            5'd9:  v = 8'd8;
            5'd10: v = 8'd60;
            5'd11: v = 8'd10;
            5'd12: v = 8'd14;
            5'd13: v = 8'd12;
            5'd14: v = 8'd26;
            5'd15: v = 8'd14;
            5'd16: v = 8'd12;
            5'd17: v = 8'd16;
            5'd18: v = 8'd24;
            5'd19: v = 8'd18;
            5'd20: v = 8'd48;
            5'd21: v = 8'd20;
            5'd22: v = 8'd96;
            5'd23: v = 8'd22;
            5'd24: v = 8'd192;
            5'd25: v = 8'd24;
            5'd26: v = 8'd72;
            5'd27: v = 8'd26;
            5'd28: v = 8'd16;
            5'd29: v = 8'd28;
            5'd30: v = 8'd32;
            default: v = 8'd30;
        endcase
        return v;
    endfunction

endpackage

// ----- design/pulse_channel_frame_sequencer.sv -----
// Top level of the pulse channel frame sequencer: input register, channels, result register.
// Depends on pcfs_pkg, pcfs_frame_seq and pcfs_channel.
//
// Control section of NUM_PULSE pulse channels plus the shared frame sequencer.
// Each input transaction is either a frame half-clock tick (tuser bit 0 low) or a
// register write (tuser bit 0 high, register select in tuser, channel and byte in
// tdata). Every input transaction yields exactly one result transaction carrying,
// for channels 0 and 1, the volume, the 11-bit timer period and the audible flag
// after the update; a channel index the block does not implement reports zeros.
// The block sustains one transaction per clock while the result side takes its results:
// an input register holds the accepted transaction, a single pass of logic updates the
// channel state, and a result register presents the outcome from the next clock edge on.
// Backpressure on the result side stalls the input register only when the result
// register is still full; there is no reset sweep.
module pulse_channel_frame_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pcfs_pkg::S_TDATA_W-1:0]  s_tdata,  // chan[0], data[8:1], zero[15:9]
    input  logic [pcfs_pkg::S_TUSER_W-1:0]  s_tuser,  // cmd[0], reg_sel[3:1]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // vol_a[3:0], vol_b[7:4], period_a[18:8], period_b[29:19],
    // audible_a[30], audible_b[31]
    output logic [pcfs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pcfs_pkg::*;

    // input register
    logic        in_vld_reg, in_vld_next;
    logic        cmd_reg;
    logic        chan_reg;
    logic [2:0]  sel_reg;
    logic [7:0]  data_reg;

    // result register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic                 s_accept;
    logic                 out_free;
    logic                 proc;
    logic                 is_tick;
    logic                 is_write;
    pcfs_frame_t          frame;
    pcfs_chan_out_t       ch_out [NUM_PULSE];
    pcfs_chan_out_t       res_a;
    pcfs_chan_out_t       res_b;

    // result register can take a new value when empty or being drained
    assign out_free = !m_tvalid_reg || m_tready;
    assign proc     = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_accept = s_tvalid && s_tready;
    assign is_tick  = proc && cmd_reg == CMD_TICK;
    assign is_write = proc && cmd_reg == CMD_WRITE;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (proc) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (proc) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            in_vld_reg   <= in_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // hold the transaction payload until it is processed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_tuser[0];
            sel_reg  <= s_tuser[3:1];
            chan_reg <= s_tdata[0];
            data_reg <= s_tdata[8:1];
        end
    end

    pcfs_frame_seq u_frame_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tick      (is_tick),
        .mode_wr   (is_write && sel_reg == REG_FRAME),
        .mode_five (data_reg[7]),
        .frame     (frame)
    );

    for (genvar c = 0; c < NUM_PULSE; c++) begin : g_chan
        pcfs_wr_t wr;

        // frame-mode writes are shared; drop them here
        assign wr.wr_en = is_write && int'(chan_reg) == c && sel_reg != REG_FRAME;
        assign wr.sel   = sel_reg;
        assign wr.data  = data_reg;

        pcfs_channel u_channel (
            .aclk    (aclk),
            .aresetn (aresetn),
            .wr      (wr),
            .frame   (frame),
            .res     (ch_out[c])
        );
    end

    // report zeros for channels the block does not implement
    if (NUM_PULSE > 0) begin : g_res_a
        assign res_a = ch_out[0];
    end else begin : g_res_a_zero
        assign res_a = '0;
    end

    if (NUM_PULSE > 1) begin : g_res_b
        assign res_b = ch_out[1];
    end else begin : g_res_b_zero
        assign res_b = '0;
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_tdata_reg <= {res_b.audible, res_a.audible, res_b.period, res_a.period,
                            res_b.vol, res_a.vol};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- design/pcfs_frame_seq.sv -----
// Frame sequencer: half-clock counter, 4/5-step mode, quarter and half frame strobes.
// Depends on pcfs_pkg.
module pcfs_frame_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 tick,
    input  logic                 mode_wr,
    input  logic                 mode_five,
    output pcfs_pkg::pcfs_frame_t frame
);
    import pcfs_pkg::*;

    logic [15:0] count_reg, count_next;
    logic        five_reg, five_next;
    logic [15:0] count_inc;
    logic        half_hit;
    logic        quarter_hit;

    assign count_inc   = count_reg + 16'd1;
    assign half_hit    = (count_inc == FRM_HALF_1)
                       || (!five_reg && count_inc == FRM_HALF_4)
                       || (five_reg && count_inc == FRM_HALF_5);
    assign quarter_hit = half_hit || count_inc == FRM_QUARTER_1 || count_inc == FRM_QUARTER_3;

    assign frame.half    = tick && half_hit;
    assign frame.quarter = tick && quarter_hit;

    always_comb begin
        count_next = count_reg;
        five_next  = five_reg;
        if (mode_wr) begin
            five_next  = mode_five;
            count_next = '0;
        end else if (tick) begin
            // return to zero one count past the last step of the sequence
            if (count_inc == (five_reg ? FRM_WRAP_5 : FRM_WRAP_4)) begin
                count_next = '0;
            end else begin
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            five_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            five_reg  <= five_next;
        end
    end

endmodule

// ----- design/pcfs_channel.sv -----
// One pulse channel: enable, length counter, envelope and sweep unit state.
// Depends on pcfs_pkg; instantiated once per channel by the top level.
module pcfs_channel (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  pcfs_pkg::pcfs_wr_t      wr,
    input  pcfs_pkg::pcfs_frame_t   frame,
    output pcfs_pkg::pcfs_chan_out_t res
);
    import pcfs_pkg::*;

    logic        en_reg, en_next;
    logic [7:0]  len_reg, len_next;
    logic [10:0] period_reg, period_next;
    logic        halt_reg, halt_next;
    logic        constv_reg, constv_next;
    logic [3:0]  eparam_reg, eparam_next;
    logic        estart_reg, estart_next;
    logic [3:0]  ediv_reg, ediv_next;
    logic [3:0]  elevel_reg, elevel_next;
    logic        son_reg, son_next;
    logic [2:0]  speriod_reg, speriod_next;
    logic        sdown_reg, sdown_next;
    logic [2:0]  sshift_reg, sshift_next;
    logic        sreload_reg, sreload_next;
    logic [2:0]  sdiv_reg, sdiv_next;
    logic [11:0] goal_reg, goal_next;
    logic        mute_reg, mute_next;

    logic        regoal;
    logic [10:0] shift_amt;
    logic [11:0] goal_calc;
    logic [3:0]  vol;

    // goal from the final period, shift and direction of this step
    assign shift_amt = period_next >> sshift_next;
    assign goal_calc = sdown_next ? ({1'b0, period_next} - {1'b0, shift_amt})
                                  : ({1'b0, period_next} + {1'b0, shift_amt});

    always_comb begin
        en_next      = en_reg;
        len_next     = len_reg;
        period_next  = period_reg;
        halt_next    = halt_reg;
        constv_next  = constv_reg;
        eparam_next  = eparam_reg;
        estart_next  = estart_reg;
        ediv_next    = ediv_reg;
        elevel_next  = elevel_reg;
        son_next     = son_reg;
        speriod_next = speriod_reg;
        sdown_next   = sdown_reg;
        sshift_next  = sshift_reg;
        sreload_next = sreload_reg;
        sdiv_next    = sdiv_reg;
        regoal       = 1'b0;

        if (wr.wr_en) begin
            unique case (wr.sel)
                REG_ENABLE: begin
                    en_next = wr.data[0];
                    if (!wr.data[0]) begin
                        len_next = '0;
                    end
                end
                REG_ENVELOPE: begin
                    eparam_next = wr.data[3:0];
                    constv_next = wr.data[4];
                    halt_next   = wr.data[5];
                end
                REG_SWEEP: begin
                    son_next     = wr.data[7];
                    speriod_next = wr.data[6:4];
                    sdown_next   = wr.data[3];
                    sshift_next  = wr.data[2:0];
                    sreload_next = 1'b1;
                    regoal       = 1'b1;
                end
                REG_TIMER_LO: begin
                    period_next = {period_reg[10:8], wr.data};
                    regoal      = 1'b1;
                end
                REG_TIMER_HI: begin
                    period_next = {wr.data[2:0], period_reg[7:0]};
                    regoal      = 1'b1;
                end
                REG_LENGTH: begin
                    if (en_reg) begin
                        len_next    = len_lookup(wr.data[4:0]);
                        estart_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (frame.half && len_reg != 8'd0 && !halt_reg) begin
            len_next = len_reg - 8'd1;
        end

        if (frame.quarter) begin
            if (estart_reg) begin
                estart_next = 1'b0;
                elevel_next = ENV_MAX;
                ediv_next   = eparam_reg;
            end else if (ediv_reg == 4'd0) begin
                ediv_next = eparam_reg;
                if (elevel_reg == 4'd0) begin
                    if (halt_reg) begin
                        elevel_next = ENV_MAX;
                    end
                end else begin
                    elevel_next = elevel_reg - 4'd1;
                end
            end else begin
                ediv_next = ediv_reg - 4'd1;
            end
        end

        if (frame.half) begin
            if (son_reg && sdiv_reg == 3'd0 && sshift_reg != 3'd0 && !mute_reg) begin
                period_next = goal_reg[10:0];
                regoal      = 1'b1;
            end
            if (sdiv_reg == 3'd0 || sreload_reg) begin
                sdiv_next    = speriod_reg;
                sreload_next = 1'b0;
            end else begin
                sdiv_next = sdiv_reg - 3'd1;
            end
        end
    end

    always_comb begin
        goal_next = goal_reg;
        mute_next = mute_reg;
        if (regoal) begin
            goal_next = goal_calc;
            mute_next = (period_next < PERIOD_MIN) || (goal_calc > {1'b0, PERIOD_MAX});
        end
    end

    assign vol         = constv_next ? eparam_next : elevel_next;
    assign res.vol     = vol;
    assign res.period  = period_next;
    assign res.audible = en_next && vol != 4'd0 && len_next != 8'd0 && !mute_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg      <= 1'b0;
            len_reg     <= LENGTH_RESET;
            period_reg  <= '0;
            halt_reg    <= 1'b0;
            constv_reg  <= 1'b0;
            eparam_reg  <= '0;
            estart_reg  <= 1'b0;
            ediv_reg    <= '0;
            elevel_reg  <= '0;
            son_reg     <= 1'b0;
            speriod_reg <= '0;
            sdown_reg   <= 1'b0;
            sshift_reg  <= '0;
            sreload_reg <= 1'b0;
            sdiv_reg    <= '0;
            goal_reg    <= '0;
            mute_reg    <= 1'b0;
        end else begin
            en_reg      <= en_next;
            len_reg     <= len_next;
            period_reg  <= period_next;
            halt_reg    <= halt_next;
            constv_reg  <= constv_next;
            eparam_reg  <= eparam_next;
            estart_reg  <= estart_next;
            ediv_reg    <= ediv_next;
            elevel_reg  <= elevel_next;
            son_reg     <= son_next;
            speriod_reg <= speriod_next;
            sdown_reg   <= sdown_next;
            sshift_reg  <= sshift_next;
            sreload_reg <= sreload_next;
            sdiv_reg    <= sdiv_next;
            goal_reg    <= goal_next;
            mute_reg    <= mute_next;
        end
    end

endmodule

// ----- design/pcfs_checker.sv -----
// Port-level checker for the pulse channel frame sequencer, bound to the top level.
// Depends on pcfs_pkg and pulse_channel_frame_sequencer_macros.svh.
`include "pulse_channel_frame_sequencer_macros.svh"

module pcfs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [pcfs_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic [pcfs_pkg::S_TUSER_W-1:0]  s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pcfs_pkg::M_TDATA_W-1:0]  m_tdata
);
    import pcfs_pkg::*;

    logic out_stall;
    logic aud_vol_ok;

    assign out_stall  = m_tvalid && !m_tready;
    assign aud_vol_ok = (!m_tdata[30] || m_tdata[3:0] != 4'd0)
                     && (!m_tdata[31] || m_tdata[7:4] != 4'd0);

    // a stalled result transaction holds its payload
    `PCFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid && $stable(m_tdata))

    // the input side backs up only behind a full, stalled result register
    `PCFS_ASSERT_IMPL(a_in_stall, aclk, aresetn, !s_tready, out_stall)

    // an audible channel never reports zero volume
    `PCFS_ASSERT_IMPL(a_aud_vol, aclk, aresetn, m_tvalid, aud_vol_ok)

    // reset empties the result register
    `PCFS_ASSERT_NEXT_ALWAYS(a_rst_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind pulse_channel_frame_sequencer pcfs_checker u_pcfs_checker (.*);

// ----- tb/pulse_channel_frame_sequencer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pulse_channel_frame_sequencer: drives frame ticks and register
// writes, predicts every status transaction and compares it field by field.
// Depends on pcfs_pkg and the design sources; nothing else.
module pulse_channel_frame_sequencer_tb;
    import pcfs_pkg::*;

    localparam int NCH = NUM_PULSE;
    // Selector the block does not decode
    localparam logic [2:0] REG_UNUSED = 3'd7;

    // Length load table, index 0 in the lowest byte
    localparam logic [255:0] LEN_TABLE = {
        8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
        8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
        8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8, 8'd160,
        8'd6, 8'd80, 8'd4, 8'd40, 8'd2, 8'd20, 8'd254, 8'd10
    };

    // One status transaction, as the block reports it after every input
    typedef struct packed {
        logic [3:0]  vol_a;
        logic [3:0]  vol_b;
        logic [10:0] period_a;
        logic [10:0] period_b;
        logic        audible_a;
        logic        audible_b;
    } pulse_status_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;  // chan[0], data[8:1], zero[15:9]
    logic [S_TUSER_W-1:0]   s_tuser  = '0;  // cmd[0], reg_sel[3:1]
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // vol_a[3:0], vol_b[7:4], period_a[18:8], period_b[29:19],
    // audible_a[30], audible_b[31]
    logic [M_TDATA_W-1:0]   m_tdata;

    // Statuses predicted for offered transactions, oldest first
    pulse_status_t pending_status[$];
    pulse_status_t want_status;
    int unsigned   mismatch_count = 0;
    int unsigned   result_idx     = 0;

    // Traffic shaping, changed by the tests right after a rising edge
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_left = 0;

    // Predictor state: per channel envelope, sweep and length, plus the frame counter
    logic        ch_on       [NCH];
    logic [7:0]  len_left    [NCH];
    logic [10:0] tmr_period  [NCH];
    logic        halt_flag   [NCH];
    logic        vol_fixed   [NCH];
    logic [3:0]  env_rate    [NCH];
    logic        env_restart [NCH];
    logic [3:0]  env_div     [NCH];
    logic [3:0]  env_vol     [NCH];
    logic        swp_on      [NCH];
    logic [2:0]  swp_rate    [NCH];
    logic        swp_neg     [NCH];
    logic [2:0]  swp_shift   [NCH];
    logic        swp_reload  [NCH];
    logic [2:0]  swp_div     [NCH];
    logic [11:0] swp_target  [NCH];
    logic        swp_muted   [NCH];
    logic [15:0] frame_count;
    logic        frame_five;

    pulse_channel_frame_sequencer u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void reset_pulse_model();
        for (int c = 0; c < NCH; c++) begin
            ch_on[c]       = 1'b0;
            len_left[c]    = LENGTH_RESET;
            tmr_period[c]  = '0;
            halt_flag[c]   = 1'b0;
            vol_fixed[c]   = 1'b0;
            env_rate[c]    = '0;
            env_restart[c] = 1'b0;
            env_div[c]     = '0;
            env_vol[c]     = '0;
            swp_on[c]      = 1'b0;
            swp_rate[c]    = '0;
            swp_neg[c]     = 1'b0;
            swp_shift[c]   = '0;
            swp_reload[c]  = 1'b0;
            swp_div[c]     = '0;
            swp_target[c]  = '0;
            swp_muted[c]   = 1'b0;
        end
        frame_count = '0;
        frame_five  = 1'b0;
    endfunction

    // Recompute the sweep target from the current period; mute on a short period or overflow
    function automatic void retarget_sweep(input int c);
        logic [11:0] p;
        logic [11:0] delta;
        logic [11:0] goal;
        p     = {1'b0, tmr_period[c]};
        delta = p >> swp_shift[c];
        goal  = swp_neg[c] ? p - delta : p + delta;
        swp_target[c] = goal;
        swp_muted[c]  = (p < {1'b0, PERIOD_MIN}) || (goal > {1'b0, PERIOD_MAX});
    endfunction

    function automatic void frame_half_clock();
        logic half_frame;
        logic quarter_frame;
        frame_count   = frame_count + 16'd1;
        half_frame    = (frame_count == FRM_HALF_1) ||
                        (!frame_five && frame_count == FRM_HALF_4) ||
                        (frame_five && frame_count == FRM_HALF_5);
        quarter_frame = half_frame || frame_count == FRM_QUARTER_1 ||
                        frame_count == FRM_QUARTER_3;
        for (int c = 0; c < NCH; c++) begin
            // Length counter: count down unless halted
            if (half_frame && len_left[c] != 8'd0 && !halt_flag[c]) begin
                len_left[c] = len_left[c] - 8'd1;
            end
            // Envelope: restart, or reload the divider at zero and step the level
            if (quarter_frame) begin
                if (env_restart[c]) begin
                    env_restart[c] = 1'b0;
                    env_vol[c]     = ENV_MAX;
                    env_div[c]     = env_rate[c];
                end else if (env_div[c] == 4'd0) begin
                    env_div[c] = env_rate[c];
                    if (env_vol[c] == 4'd0) begin
                        if (halt_flag[c]) env_vol[c] = ENV_MAX;
                    end else begin
                        env_vol[c] = env_vol[c] - 4'd1;
                    end
                end else begin
                    env_div[c] = env_div[c] - 4'd1;
                end
            end
            // Sweep: apply the target when the divider expires, then reload or count down
            if (half_frame) begin
                if (swp_on[c] && swp_div[c] == 3'd0 && swp_shift[c] != 3'd0 && !swp_muted[c]) begin
                    tmr_period[c] = swp_target[c][10:0];
                    retarget_sweep(c);
                end
                if (swp_div[c] == 3'd0 || swp_reload[c]) begin
                    swp_div[c]    = swp_rate[c];
                    swp_reload[c] = 1'b0;
                end else begin
                    swp_div[c] = swp_div[c] - 3'd1;
                end
            end
        end
        if (frame_count == (frame_five ? FRM_WRAP_5 : FRM_WRAP_4)) frame_count = '0;
    endfunction

    function automatic void register_write(input logic chan, input logic [2:0] sel,
                                           input logic [7:0] d);
        int c;
        c = int'(chan);
        if (sel == REG_FRAME) begin
            frame_five  = d[7];
            frame_count = '0;
        end else if (c < NCH) begin
            case (sel)
                REG_ENABLE: begin
                    ch_on[c] = d[0];
                    if (!d[0]) len_left[c] = 8'd0;
                end
                REG_ENVELOPE: begin
                    env_rate[c]  = d[3:0];
                    vol_fixed[c] = d[4];
                    halt_flag[c] = d[5];
                end
                REG_SWEEP: begin
                    swp_on[c]     = d[7];
                    swp_rate[c]   = d[6:4];
                    swp_neg[c]    = d[3];
                    swp_shift[c]  = d[2:0];
                    swp_reload[c] = 1'b1;
                    retarget_sweep(c);
                end
                REG_TIMER_LO: begin
                    tmr_period[c] = {tmr_period[c][10:8], d};
                    retarget_sweep(c);
                end
                REG_TIMER_HI: begin
                    tmr_period[c] = {d[2:0], tmr_period[c][7:0]};
                    retarget_sweep(c);
                end
                REG_LENGTH: begin
                    if (ch_on[c]) begin
                        len_left[c]    = LEN_TABLE[{d[4:0], 3'b000} +: 8];
                        env_restart[c] = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    endfunction

    // Apply one input transaction and return the status the block must report after it
    function automatic pulse_status_t advance_pulse_model(input logic cmd, input logic chan,
                                                          input logic [2:0] sel,
                                                          input logic [7:0] d);
        pulse_status_t     s;
        logic [1:0][3:0]   vol;
        logic [1:0][10:0]  per;
        logic [1:0]        aud;
        if (cmd == CMD_WRITE) register_write(chan, sel, d);
        else frame_half_clock();
        for (int k = 0; k < 2; k++) begin
            vol[k] = '0;
            per[k] = '0;
            aud[k] = 1'b0;
            // A channel the block does not implement reports zeros
            if (k < NCH) begin
                vol[k] = vol_fixed[k] ? env_rate[k] : env_vol[k];
                per[k] = tmr_period[k];
                aud[k] = ch_on[k] && vol[k] != 4'd0 && len_left[k] != 8'd0 && !swp_muted[k];
            end
        end
        s.vol_a     = vol[0];
        s.vol_b     = vol[1];
        s.period_a  = per[0];
        s.period_b  = per[1];
        s.audible_a = aud[0];
        s.audible_b = aud[1];
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offer one transaction at a falling edge after a random gap and return at the
    // rising edge that accepts it. Leave tvalid high: the next call or wait_drained
    // lowers it, so tvalid never gets two updates in one time step.
    task automatic send_item(input logic cmd, input logic chan, input logic [2:0] sel,
                             input logic [7:0] d);
        @(negedge aclk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= {7'd0, d, chan};
        s_tuser  <= {sel, cmd};
        s_tvalid <= 1'b1;
        pending_status.push_back(advance_pulse_model(cmd, chan, sel, d));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop tvalid and hold off until every predicted status has come back
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_status.size() != 0);
    endtask

    // Tick or write with random fields; ticks carry random don't-care fields too
    task automatic send_random_item();
        if ($urandom_range(99) < 35) begin
            send_item(CMD_TICK, 1'($urandom_range(1)), 3'($urandom_range(7)),
                      8'($urandom_range(255)));
        end else begin
            send_item(CMD_WRITE, 1'($urandom_range(1)), 3'($urandom_range(7)),
                      8'($urandom_range(255)));
        end
    endtask

    // Program one channel in the usual order with random content, mostly enabled
    task automatic setup_channel(input logic c);
        logic [7:0] d;
        d = 8'($urandom_range(255));
        if ($urandom_range(9) != 0) d[0] = 1'b1;
        send_item(CMD_WRITE, c, REG_ENABLE, d);
        d = 8'($urandom_range(255));
        if ($urandom_range(1) != 0) d[3:0] = 4'd0;
        send_item(CMD_WRITE, c, REG_ENVELOPE, d);
        d = 8'($urandom_range(255));
        if ($urandom_range(1) != 0) d[6:4] = 3'd0;
        send_item(CMD_WRITE, c, REG_SWEEP, d);
        send_item(CMD_WRITE, c, REG_TIMER_LO, 8'($urandom_range(255)));
        send_item(CMD_WRITE, c, REG_TIMER_HI, 8'($urandom_range(255)));
        send_item(CMD_WRITE, c, REG_LENGTH, 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------
    // Stall the result channel at random, or hold it off for a counted stretch
    always @(negedge aclk) begin
        if (rx_hold_left > 0) begin
            m_tready <= 1'b0;
            rx_hold_left = rx_hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < 40) begin
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, result_idx, what, got, want);
        end
        mismatch_count++;
    endtask

    // Compare each accepted status transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("status with nothing pending", m_tdata, 32'd0);
            end else begin
                want_status = pending_status.pop_front();
                if (m_tdata[3:0] !== want_status.vol_a)
                    report_mismatch("vol_a", 32'(m_tdata[3:0]), 32'(want_status.vol_a));
                if (m_tdata[7:4] !== want_status.vol_b)
                    report_mismatch("vol_b", 32'(m_tdata[7:4]), 32'(want_status.vol_b));
                if (m_tdata[18:8] !== want_status.period_a)
                    report_mismatch("period_a", 32'(m_tdata[18:8]),
                                    32'(want_status.period_a));
                if (m_tdata[29:19] !== want_status.period_b)
                    report_mismatch("period_b", 32'(m_tdata[29:19]),
                                    32'(want_status.period_b));
                if (m_tdata[30] !== want_status.audible_a)
                    report_mismatch("audible_a", 32'(m_tdata[30]),
                                    32'(want_status.audible_a));
                if (m_tdata[31] !== want_status.audible_b)
                    report_mismatch("audible_b", 32'(m_tdata[31]),
                                    32'(want_status.audible_b));
            end
            result_idx++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Field extremes, every selector and the corner cases, back to back
    task automatic test_directed_edges();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        // Reset state: length 7 but both channels disabled
        send_item(CMD_TICK, 1'b0, REG_ENABLE, 8'h00);
        // Unused selector must leave everything alone
        send_item(CMD_WRITE, 1'b1, REG_UNUSED, 8'hff);
        send_item(CMD_WRITE, 1'b0, REG_ENABLE, 8'hff);
        send_item(CMD_WRITE, 1'b1, REG_ENABLE, 8'h01);
        // Constant volume 15 with halt; duty bits are ignored
        send_item(CMD_WRITE, 1'b0, REG_ENVELOPE, 8'hff);
        send_item(CMD_WRITE, 1'b1, REG_ENVELOPE, 8'h00);
        // Period 2047; only timer high bits 2..0 count
        send_item(CMD_WRITE, 1'b0, REG_TIMER_LO, 8'hff);
        send_item(CMD_WRITE, 1'b0, REG_TIMER_HI, 8'hff);
        // Shift 0 upward doubles the period past the limit: muted
        send_item(CMD_WRITE, 1'b0, REG_SWEEP, 8'h00);
        send_item(CMD_WRITE, 1'b0, REG_SWEEP, 8'hff);
        // Period below the minimum mutes, then right at it
        send_item(CMD_WRITE, 1'b1, REG_TIMER_LO, 8'h07);
        send_item(CMD_WRITE, 1'b1, REG_TIMER_HI, 8'hf8);
        send_item(CMD_WRITE, 1'b1, REG_TIMER_LO, 8'h08);
        // Last and first table entries; the load restarts the envelope
        send_item(CMD_WRITE, 1'b0, REG_LENGTH, 8'hff);
        send_item(CMD_WRITE, 1'b1, REG_LENGTH, 8'h00);
        send_item(CMD_WRITE, 1'b1, REG_ENVELOPE, 8'h1f);
        // Disable clears the length; a load while disabled is dropped
        send_item(CMD_WRITE, 1'b1, REG_ENABLE, 8'hfe);
        send_item(CMD_WRITE, 1'b1, REG_LENGTH, 8'h01);
        // Frame mode both ways, from either channel field
        send_item(CMD_WRITE, 1'b0, REG_FRAME, 8'h80);
        send_item(CMD_TICK, 1'b1, REG_FRAME, 8'hff);
        send_item(CMD_WRITE, 1'b1, REG_FRAME, 8'h7f);
        send_item(CMD_TICK, 1'b0, REG_ENABLE, 8'h00);
        wait_drained();
    endtask

    // Random ticks, writes and channel setups under each idle pattern
    task automatic test_random_traffic();
        int sent;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            sent = 0;
            while (sent < 90) begin
                if ($urandom_range(99) < 40) begin
                    setup_channel(1'($urandom_range(1)));
                    sent += 6;
                end else begin
                    send_random_item();
                    sent++;
                end
            end
        end
    endtask

    // Hold the result side off long enough to fill the block and stall its input
    task automatic test_result_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        wait_drained();
        rx_hold_left = 300;
        repeat (40) send_random_item();
        // Pause with everything delivered, then burst again under heavy stalls
        wait_drained();
        rx_stall_pct = 68;
        repeat (40) send_random_item();
        wait_drained();
    endtask

    // Step the frame counter in 4-step then 5-step mode, with channel writes mixed
    // in between the ticks.
    task automatic test_frame_sequencer();
        logic [7:0] d;
        for (int blk = 0; blk < 2; blk++) begin
            tx_idle_pct  = (blk == 0) ? 11 : 0;
            rx_stall_pct = (blk == 0) ? 11 : 68;
            d    = 8'($urandom_range(255));
            d[7] = blk[0];
            send_item(CMD_WRITE, 1'($urandom_range(1)), REG_FRAME, d);
            repeat (24) begin
                if ($urandom_range(3) == 0) begin
                    send_item(CMD_WRITE, 1'($urandom_range(1)),
                              3'($urandom_range(REG_LENGTH)), 8'($urandom_range(255)));
                end else begin
                    send_item(CMD_TICK, 1'($urandom_range(1)), 3'($urandom_range(7)),
                              8'($urandom_range(255)));
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_pulse_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_edges();
        test_random_traffic();
        test_result_backpressure();
        test_frame_sequencer();
        wait_drained();
        // Let the pipeline settle so any stray status transaction gets caught
        repeat (10) @(posedge aclk);
        if (pending_status.size() != 0)
            report_mismatch("statuses never delivered", pending_status.size(), 32'd0);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: the slowest correct run stays well under a tenth of this
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
